// ----- src/m2q_pkg.sv -----
// Shared widths, payload types and latency for the matrix-to-quaternion pipeline.
package m2q_pkg;

    localparam int DW       = 16;
    localparam int FRAC     = DW - 2;
    localparam int VW       = DW + 3;
    localparam int MW       = DW + 1;
    localparam int SQW      = 2 * MW;
    localparam int N2W      = SQW + 2;
    localparam int RW       = N2W + 1;
    localparam int SQ_STEPS = N2W / 2;
    localparam int NW       = SQ_STEPS;
    localparam int DENW     = NW + 1;
    localparam int QW       = FRAC + 1;
    localparam int REMW     = MW + FRAC + 2;
    localparam int LAT      = 3 + SQ_STEPS + 1 + QW + 1;

    localparam logic signed [DW-1:0] ONE_Q = DW'(1 << FRAC);

    typedef struct packed {
        logic signed [DW-1:0] m00;
        logic signed [DW-1:0] m01;
        logic signed [DW-1:0] m02;
        logic signed [DW-1:0] m10;
        logic signed [DW-1:0] m11;
        logic signed [DW-1:0] m12;
        logic signed [DW-1:0] m20;
        logic signed [DW-1:0] m21;
        logic signed [DW-1:0] m22;
    } t_mat;

    typedef struct packed {
        logic signed [DW-1:0] qw;
        logic signed [DW-1:0] qx;
        logic signed [DW-1:0] qy;
        logic signed [DW-1:0] qz;
        logic                 degenerate;
    } t_quat;

    typedef struct packed {
        logic [3:0][MW-1:0] mag;
        logic [3:0]         neg;
        logic               degen;
    } t_comp;

endpackage

// ----- src/m2q_front.sv -----
// Front stages: component vector, magnitudes and squares, squared norm.
module m2q_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  m2q_pkg::t_mat     i_mat,
    output logic              o_vld,
    output m2q_pkg::t_comp    o_comp,
    output logic [m2q_pkg::N2W-1:0] o_n2
);
    import m2q_pkg::*;

    logic signed [VW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22, trace, s;
    logic signed [VW-1:0] n_v [0:3];
    logic                 n_deg;
    logic signed [VW-1:0] r_v [0:3];
    logic                 r_a_deg, r_a_vld;
    logic [3:0][MW-1:0]   n_mag;
    logic [3:0]           n_neg;
    logic [3:0][SQW-1:0]  r_sq;
    t_comp                r_b_comp, r_c_comp;
    logic                 r_b_vld, r_c_vld;
    logic [N2W-1:0]       r_n2;

    always_comb begin
        e00 = VW'(i_mat.m00); e01 = VW'(i_mat.m01); e02 = VW'(i_mat.m02);
        e10 = VW'(i_mat.m10); e11 = VW'(i_mat.m11); e12 = VW'(i_mat.m12);
        e20 = VW'(i_mat.m20); e21 = VW'(i_mat.m21); e22 = VW'(i_mat.m22);
        trace = e00 + e11 + e22;
        s = '0;
        n_deg = 1'b0;
        if (trace > 0) begin
            n_v[0] = trace + VW'(ONE_Q);
            n_v[1] = e21 - e12;
            n_v[2] = e02 - e20;
            n_v[3] = e10 - e01;
        end else if (e22 > e00 && e22 > e11) begin
            s = e22 - e00 - e11 + VW'(ONE_Q);
            n_v[3] = s;
            n_v[0] = e10 - e01;
            n_v[1] = e02 + e20;
            n_v[2] = e12 + e21;
        end else if (e11 > e00) begin
            s = e11 - e22 - e00 + VW'(ONE_Q);
            n_v[2] = s;
            n_v[0] = e02 - e20;
            n_v[3] = e21 + e12;
            n_v[1] = e01 + e10;
        end else begin
            s = e00 - e11 - e22 + VW'(ONE_Q);
            n_v[1] = s;
            n_v[0] = e21 - e12;
            n_v[2] = e10 + e01;
            n_v[3] = e20 + e02;
        end
        if (trace <= 0 && s <= 0) begin
            n_deg = 1'b1;
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_neg[c] = r_v[c][VW-1];
            n_mag[c] = n_neg[c] ? MW'(-r_v[c]) : MW'(r_v[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 4; c++) begin
            r_v[c]  <= n_v[c];
            r_sq[c] <= SQW'(n_mag[c]) * SQW'(n_mag[c]);
        end
        r_a_deg        <= n_deg;
        r_b_comp.mag   <= n_mag;
        r_b_comp.neg   <= n_neg;
        r_b_comp.degen <= r_a_deg;
        r_c_comp       <= r_b_comp;
        r_n2 <= N2W'(r_sq[0]) + N2W'(r_sq[1]) + N2W'(r_sq[2]) + N2W'(r_sq[3]);
    end

    assign o_vld  = r_c_vld;
    assign o_comp = r_c_comp;
    assign o_n2   = r_n2;

endmodule

// ----- src/m2q_sqrt.sv -----
// Pipelined integer square root of the squared norm, one root bit per stage.
module m2q_sqrt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  m2q_pkg::t_comp          i_comp,
    input  logic [m2q_pkg::N2W-1:0] i_n2,
    output logic                    o_vld,
    output m2q_pkg::t_comp          o_comp,
    output logic [m2q_pkg::NW-1:0]  o_n
);
    import m2q_pkg::*;

    logic [N2W-1:0] x_p   [0:SQ_STEPS];
    logic [RW-1:0]  res_p [0:SQ_STEPS];
    t_comp          cmp_p [0:SQ_STEPS];
    logic [SQ_STEPS:0] vld_p;
    logic [N2W-1:0] r_x   [0:SQ_STEPS-1];
    logic [RW-1:0]  r_res [0:SQ_STEPS-1];
    t_comp          r_cmp [0:SQ_STEPS-1];
    logic [SQ_STEPS-1:0] r_vld;

    assign x_p[0]   = i_n2;
    assign res_p[0] = '0;
    assign cmp_p[0] = i_comp;
    assign vld_p[0] = i_vld;

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_step
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQ_STEPS - 1 - g));
        logic [RW-1:0]  sum;
        logic [N2W-1:0] n_x;
        logic [RW-1:0]  n_res;

        always_comb begin
            sum = res_p[g] + BIT;
            if ({1'b0, x_p[g]} >= sum) begin
                n_x   = x_p[g] - sum[N2W-1:0];
                n_res = (res_p[g] >> 1) + BIT;
            end else begin
                n_x   = x_p[g];
                n_res = res_p[g] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= vld_p[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[g]   <= n_x;
            r_res[g] <= n_res;
            r_cmp[g] <= cmp_p[g];
        end

        assign x_p[g+1]   = r_x[g];
        assign res_p[g+1] = r_res[g];
        assign cmp_p[g+1] = r_cmp[g];
        assign vld_p[g+1] = r_vld[g];
    end

    assign o_vld  = vld_p[SQ_STEPS];
    assign o_comp = cmp_p[SQ_STEPS];
    assign o_n    = res_p[SQ_STEPS][NW-1:0];

endmodule

// ----- src/m2q_div.sv -----
// Four-lane pipelined restoring divider: round(mag * ONE / n), one quotient bit per stage.
module m2q_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_vld,
    input  m2q_pkg::t_comp         i_comp,
    input  logic [m2q_pkg::NW-1:0] i_n,
    output logic                   o_vld,
    output logic [3:0][m2q_pkg::QW-1:0] o_q,
    output logic [3:0]             o_neg,
    output logic                   o_degen
);
    import m2q_pkg::*;

    logic [3:0][REMW-1:0] r_rem [0:QW];
    logic [3:0][QW-1:0]   r_q   [0:QW];
    logic [DENW-1:0]      r_den [0:QW];
    logic [3:0]           r_neg [0:QW];
    logic                 r_deg [0:QW];
    logic [QW:0]          r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[QW-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 4; c++) begin
            r_rem[0][c] <= (REMW'(i_comp.mag[c]) << (FRAC + 1)) + REMW'(i_n);
        end
        r_q[0]   <= '0;
        r_den[0] <= {i_n, 1'b0};
        r_neg[0] <= i_comp.neg;
        r_deg[0] <= i_comp.degen || (i_n == '0);
    end

    for (genvar g = 0; g < QW; g++) begin : g_step
        localparam int P = QW - 1 - g;
        logic [REMW-1:0]      trial;
        logic [3:0][REMW-1:0] n_rem;
        logic [3:0][QW-1:0]   n_q;

        always_comb begin
            trial = REMW'(r_den[g]) << P;
            for (int c = 0; c < 4; c++) begin
                n_rem[c] = r_rem[g][c];
                n_q[c]   = r_q[g][c];
                if (r_rem[g][c] >= trial) begin
                    n_rem[c]  = r_rem[g][c] - trial;
                    n_q[c][P] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g+1] <= n_rem;
            r_q[g+1]   <= n_q;
            r_den[g+1] <= r_den[g];
            r_neg[g+1] <= r_neg[g];
            r_deg[g+1] <= r_deg[g];
        end
    end

    assign o_vld   = r_vld[QW];
    assign o_q     = r_q[QW];
    assign o_neg   = r_neg[QW];
    assign o_degen = r_deg[QW];

endmodule

// ----- src/matrix_to_quaternion_top.sv -----
// Top level: rotation matrix to unit quaternion, fully pipelined.
//
// Usage:
//   Drive the nine matrix entries (signed Q1.14) on i_mat and pulse start.
//   busy is always low, so a transaction is taken at every edge where start
//   is high; a new matrix may enter in every cycle.
//   Each result appears on o_quat for exactly one cycle with o_valid high,
//   once it has passed every stage listed below, in order of entry.
//   The pipeline holds 3 front stages (vector, squares, norm
//   sum), 18 square-root stages (one root bit each), 1 divider setup stage,
//   15 divider stages (one quotient bit each) and the output register.
//   Throughput is one transaction per cycle.
//   o_quat.degenerate flags the identity result given for a zero root or
//   a non-positive trace and diagonal pivot.
//   Synchronous reset clears all valid bits; items in flight are dropped.
//   The receiver has no backpressure and must take every strobed result.
module matrix_to_quaternion_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  m2q_pkg::t_mat   i_mat,
    output logic            o_valid,
    output m2q_pkg::t_quat  o_quat
);
    import m2q_pkg::*;

    logic               f_vld, s_vld, d_vld;
    t_comp              f_comp, s_comp;
    logic [N2W-1:0]     f_n2;
    logic [NW-1:0]      s_n;
    logic [3:0][QW-1:0] d_q;
    logic [3:0]         d_neg;
    logic               d_degen;
    logic signed [DW-1:0] n_c [0:3];
    logic               r_valid;
    t_quat              r_quat;

    assign busy = 1'b0;

    m2q_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(start && !busy), .i_mat(i_mat),
        .o_vld(f_vld), .o_comp(f_comp), .o_n2(f_n2)
    );

    m2q_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(f_vld), .i_comp(f_comp), .i_n2(f_n2),
        .o_vld(s_vld), .o_comp(s_comp), .o_n(s_n)
    );

    m2q_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(s_vld), .i_comp(s_comp), .i_n(s_n),
        .o_vld(d_vld), .o_q(d_q), .o_neg(d_neg), .o_degen(d_degen)
    );

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_c[c] = d_neg[c] ? -DW'({1'b0, d_q[c]}) : DW'({1'b0, d_q[c]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_degen) begin
            r_quat.qw <= ONE_Q;
            r_quat.qx <= '0;
            r_quat.qy <= '0;
            r_quat.qz <= '0;
        end else begin
            r_quat.qw <= n_c[0];
            r_quat.qx <= n_c[1];
            r_quat.qy <= n_c[2];
            r_quat.qz <= n_c[3];
        end
        r_quat.degenerate <= d_degen;
    end

    assign o_valid = r_valid;
    assign o_quat  = r_quat;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_valid)
        else $error("result missing at pipeline latency");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start ##1 1'b1 |-> ##(LAT-1) !o_valid)
        else $error("result without a transaction");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_quat.qw <= ONE_Q && o_quat.qw >= -ONE_Q
                  && o_quat.qx <= ONE_Q && o_quat.qx >= -ONE_Q))
        else $error("component exceeds unit magnitude");

    a_degen_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_quat.degenerate |-> o_quat.qw == ONE_Q && o_quat.qy == '0)
        else $error("degenerate result is not identity");

endmodule
